// ===== hw/rtl/kruskal_spanning_tree_unit_defines.svh =====
// assertion macros used by the spanning tree unit datapath
`ifndef KRUSKAL_SPANNING_TREE_UNIT_DEFINES_SVH
`define KRUSKAL_SPANNING_TREE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kst_pkg.sv =====
// types, constants and state codes of the spanning tree unit
package kst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int EIDX_W       = $clog2(MAX_EDGES);
    localparam int ECNT_W       = EIDX_W + 1;
    localparam int VID_W        = 6;
    localparam int VCNT_W       = 7;
    localparam int WGT_W        = 16;
    localparam int ID_W         = 8;
    localparam int CIDX_W       = 1;

    localparam logic [CIDX_W-1:0] CFG_WEIGHT_SELECT = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_VERTEX_COUNT  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  edge_id;
        logic [VID_W-1:0] end_a;
        logic [VID_W-1:0] end_b;
        logic [WGT_W-1:0] weight_a;
        logic [WGT_W-1:0] weight_b;
        logic             final_edge;
    } edge_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  tree_edge_id;
        logic [VID_W-1:0] tree_end_a;
        logic [VID_W-1:0] tree_end_b;
        logic             no_edge;
        logic             last_result;
    } tree_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VID_W-1:0] a;
        logic [VID_W-1:0] b;
        logic [WGT_W-1:0] wa;
        logic [WGT_W-1:0] wb;
    } edge_rec_t;

    localparam int REC_W = $bits(edge_rec_t);

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_SCAN_START,
        S_SCAN,
        S_FETCH,
        S_EDGE,
        S_CHECK,
        S_LB,
        S_CMP,
        S_RD,
        S_WR,
        S_EMIT,
        S_FINISH
    } kst_state_t;

    typedef struct packed {
        logic load_edge;
        logic init_wr;
        logic v_clr;
        logic scan_clr;
        logic scan_step;
        logic take_best;
        logic edge_latch;
        logic la_rd;
        logic lb_rd;
        logic lb_latch;
        logic relabel_rd;
        logic relabel_wr;
        logic emit;
        logic finish;
    } kst_cmd_t;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic best_found;
        logic ends_ok;
        logic same_label;
        logic v_last;
        logic out_free;
    } kst_status_t;

endpackage

// ===== hw/rtl/kst_ram.sv =====
// generic single write port ram with registered read
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/kst_ctrl.sv =====
// sequencer for load, ordered scan, union and result emission
module kst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                edge_valid,
    input  logic                edge_final,
    output logic                edge_ready,
    input  kst_pkg::kst_status_t status,
    output kst_pkg::kst_cmd_t   cmd
);
    import kst_pkg::*;

    kst_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        edge_ready = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                edge_ready = 1'b1;
                if (edge_valid)
                begin
                    cmd.load_edge = 1'b1;
                    if (edge_final)
                    begin
                        cmd.v_clr  = 1'b1;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.init_done)
                begin
                    state_next = S_SCAN_START;
                end
            end
            S_SCAN_START:
            begin
                cmd.scan_clr = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = status.best_found ? S_FETCH : S_FINISH;
                end
            end
            S_FETCH:
            begin
                cmd.take_best = 1'b1;
                state_next    = S_EDGE;
            end
            S_EDGE:
            begin
                cmd.edge_latch = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.ends_ok)
                begin
                    cmd.la_rd  = 1'b1;
                    state_next = S_LB;
                end
                else
                begin
                    state_next = S_SCAN_START;
                end
            end
            S_LB:
            begin
                cmd.lb_rd  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.lb_latch = 1'b1;
                cmd.v_clr    = 1'b1;
                state_next   = status.same_label ? S_SCAN_START : S_RD;
            end
            S_RD:
            begin
                cmd.relabel_rd = 1'b1;
                state_next     = S_WR;
            end
            S_WR:
            begin
                cmd.relabel_wr = 1'b1;
                state_next     = status.v_last ? S_EMIT : S_RD;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_SCAN_START;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end
endmodule

// ===== hw/rtl/kst_dpath.sv =====
// edge store, label memory, ordered minimum search and output register
module kst_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kst_pkg::kst_cmd_t    cmd,
    output kst_pkg::kst_status_t status,
    input  kst_pkg::edge_item_t  edge_item,
    input  logic                 cfg_valid,
    input  logic [kst_pkg::CIDX_W-1:0] cfg_index,
    input  logic [kst_pkg::VCNT_W-1:0] cfg_data,
    output logic                 tree_valid,
    input  logic                 tree_ready,
    output kst_pkg::tree_item_t  tree_item
);
    import kst_pkg::*;
    `include "kruskal_spanning_tree_unit_defines.svh"

    logic               wsel_reg;
    logic [VCNT_W-1:0]  vcount_reg;
    logic [VCNT_W-1:0]  nv_eff;
    logic [VID_W-1:0]   nv_m1;

    logic [ECNT_W-1:0]  total_reg;
    logic [ECNT_W-1:0]  j_reg;
    logic               rd_valid_reg;
    logic [EIDX_W-1:0]  rd_idx_reg;
    logic               best_valid_reg;
    logic [WGT_W-1:0]   best_w_reg;
    logic [EIDX_W-1:0]  best_idx_reg;
    logic               prev_valid_reg;
    logic [WGT_W-1:0]   prev_w_reg;
    logic [EIDX_W-1:0]  prev_idx_reg;
    edge_rec_t          edge_reg;
    logic [VID_W-1:0]   v_reg;
    logic [VID_W-1:0]   la_reg;
    logic [VID_W-1:0]   lb_reg;
    logic               pend_valid_reg;
    edge_rec_t          pend_reg;
    logic               out_valid_reg;
    tree_item_t         out_reg;

    logic               st_we, st_re;
    logic [EIDX_W-1:0]  st_raddr;
    logic [REC_W-1:0]   st_q;
    edge_rec_t          st_rec;
    edge_rec_t          in_rec;
    logic               lb_we, lb_re;
    logic [VID_W-1:0]   lb_waddr, lb_wdata, lb_raddr, lb_q;

    logic [WGT_W-1:0]   cand_w;
    logic               qualifies, better, scan_issue, out_free;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsel_reg   <= 1'b0;
            vcount_reg <= VCNT_W'(MAX_VERTICES);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_SELECT: wsel_reg   <= cfg_data[0];
                CFG_VERTEX_COUNT:  vcount_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (vcount_reg == '0)
        begin
            nv_eff = VCNT_W'(1);
        end
        else if (vcount_reg > VCNT_W'(MAX_VERTICES))
        begin
            nv_eff = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            nv_eff = vcount_reg;
        end
    end
    assign nv_m1 = VID_W'(nv_eff - VCNT_W'(1));

    // edge store
    assign in_rec.id = edge_item.edge_id;
    assign in_rec.a  = edge_item.end_a;
    assign in_rec.b  = edge_item.end_b;
    assign in_rec.wa = edge_item.weight_a;
    assign in_rec.wb = edge_item.weight_b;

    assign st_we      = cmd.load_edge && (total_reg < ECNT_W'(MAX_EDGES));
    assign scan_issue = cmd.scan_step && (j_reg < total_reg);
    assign st_re      = scan_issue || cmd.take_best;
    assign st_raddr   = cmd.take_best ? best_idx_reg : j_reg[EIDX_W-1:0];
    assign st_rec     = edge_rec_t'(st_q);

    kst_ram #(.WIDTH(REC_W), .DEPTH(MAX_EDGES)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (total_reg[EIDX_W-1:0]),
        .wdata (REC_W'(in_rec)),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_q)
    );

    // component labels
    always_comb
    begin
        lb_we    = 1'b0;
        lb_waddr = v_reg;
        lb_wdata = v_reg;
        if (cmd.init_wr)
        begin
            lb_we = 1'b1;
        end
        else if (cmd.relabel_wr && (lb_q == la_reg))
        begin
            lb_we    = 1'b1;
            lb_wdata = lb_reg;
        end
    end

    assign lb_re = cmd.la_rd || cmd.lb_rd || cmd.relabel_rd;
    always_comb
    begin
        priority if (cmd.la_rd)
        begin
            lb_raddr = edge_reg.a;
        end
        else if (cmd.lb_rd)
        begin
            lb_raddr = edge_reg.b;
        end
        else
        begin
            lb_raddr = v_reg;
        end
    end

    kst_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_label (
        .clk   (clk),
        .we    (lb_we),
        .waddr (lb_waddr),
        .wdata (lb_wdata),
        .re    (lb_re),
        .raddr (lb_raddr),
        .rdata (lb_q)
    );

    // next edge in stable weight order: smallest key above the previous key
    assign cand_w    = wsel_reg ? st_rec.wb : st_rec.wa;
    assign qualifies = !prev_valid_reg || (cand_w > prev_w_reg)
                       || ((cand_w == prev_w_reg) && (rd_idx_reg > prev_idx_reg));
    assign better    = !best_valid_reg || (cand_w < best_w_reg);
    assign out_free  = !out_valid_reg || tree_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            j_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            v_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (st_we)
            begin
                total_reg <= total_reg + ECNT_W'(1);
            end
            if (cmd.v_clr)
            begin
                v_reg <= '0;
            end
            else if (cmd.init_wr || cmd.relabel_wr)
            begin
                v_reg <= v_reg + VID_W'(1);
            end
            if (cmd.load_edge && edge_item.final_edge)
            begin
                prev_valid_reg <= 1'b0;
            end
            else if (cmd.take_best)
            begin
                prev_valid_reg <= 1'b1;
            end
            if (cmd.scan_clr)
            begin
                j_reg          <= '0;
                rd_valid_reg   <= 1'b0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    j_reg <= j_reg + ECNT_W'(1);
                end
                if (rd_valid_reg && qualifies && better)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else if (tree_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
                total_reg      <= '0;
            end
            else if (tree_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && rd_valid_reg && qualifies && better)
        begin
            best_w_reg   <= cand_w;
            best_idx_reg <= rd_idx_reg;
        end
        if (scan_issue)
        begin
            rd_idx_reg <= j_reg[EIDX_W-1:0];
        end
        if (cmd.take_best)
        begin
            prev_w_reg   <= best_w_reg;
            prev_idx_reg <= best_idx_reg;
        end
        if (cmd.edge_latch)
        begin
            edge_reg <= st_rec;
        end
        if (cmd.lb_rd)
        begin
            la_reg <= lb_q;
        end
        if (cmd.lb_latch)
        begin
            lb_reg <= lb_q;
        end
        if (cmd.emit)
        begin
            pend_reg <= edge_reg;
            if (pend_valid_reg)
            begin
                out_reg <= '{pend_reg.id, pend_reg.a, pend_reg.b, 1'b0, 1'b0};
            end
        end
        else if (cmd.finish)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= '{pend_reg.id, pend_reg.a, pend_reg.b, 1'b0, 1'b1};
            end
            else
            begin
                out_reg <= '{'0, '0, '0, 1'b1, 1'b1};
            end
        end
    end

    assign status.init_done  = (v_reg == VID_W'(MAX_VERTICES - 1));
    assign status.scan_done  = (j_reg == total_reg) && !rd_valid_reg;
    assign status.best_found = best_valid_reg;
    assign status.ends_ok    = ({1'b0, edge_reg.a} < nv_eff) && ({1'b0, edge_reg.b} < nv_eff);
    assign status.same_label = (lb_q == la_reg);
    assign status.v_last     = (v_reg == nv_m1);
    assign status.out_free   = out_free;

    assign tree_valid = out_valid_reg;
    assign tree_item  = out_reg;

    `KST_ASSERT_NEXT(a_total_clr, cmd.finish, total_reg == '0, "edge count not cleared after run")
    `KST_ASSERT_NOW(a_order_up, best_valid_reg && prev_valid_reg, best_w_reg >= prev_w_reg, "scan picked an edge below the previous weight")
    `KST_ASSERT_NOW(a_no_edge, out_valid_reg && out_reg.no_edge, out_reg.last_result && (out_reg.tree_edge_id == '0), "no-edge item malformed")
endmodule

// ===== hw/rtl/kruskal_spanning_tree_unit.sv =====
// Minimum spanning tree unit: edges load one item per cycle into a 256-entry store
// until the item marked final_edge. The run then first writes the 64-entry label memory,
// and finds each next edge in stable weight order by a full scan of the store (one
// pass per stored edge plus one), and each union relabels vertices up to vertex_count.
// Tree edges leave in order; the last carries last_result, and a run with no union
// gives one no_edge item. No edge is taken while a run is in progress.
module kruskal_spanning_tree_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 edge_valid,
    output logic                 edge_ready,
    input  kst_pkg::edge_item_t  edge_item,
    output logic                 tree_valid,
    input  logic                 tree_ready,
    output kst_pkg::tree_item_t  tree_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [kst_pkg::CIDX_W-1:0] cfg_index,
    input  logic [kst_pkg::VCNT_W-1:0] cfg_data
);
    import kst_pkg::*;

    kst_cmd_t    cmd;
    kst_status_t status;

    assign cfg_ready = 1'b1;

    kst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .edge_final (edge_item.final_edge),
        .edge_ready (edge_ready),
        .status     (status),
        .cmd        (cmd)
    );

    kst_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .edge_item  (edge_item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tree_valid (tree_valid),
        .tree_ready (tree_ready),
        .tree_item  (tree_item)
    );
endmodule
